[rtl/rle_lse_pkg.sv]
package rle_lse_pkg;

    // Default limits for literal segments and runs
    localparam int LIT_MAX_DEF = 255;
    localparam int RUN_MAX_DEF = 255;

    // Byte lanes in one output word
    localparam int LANES = 8;

    // Input beat: one raw byte and the end-of-stream flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } item_t;

    // Output beat: up to eight encoded bytes, earliest in bits 7:0
    typedef struct packed {
        logic [63:0] packed_bytes;
        logic [3:0]  byte_count;
        logic        last_of_item;
        logic        stream_done;
    } word_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_POST,
        ST_LIT_HDR0,
        ST_LIT_HDR1,
        ST_LIT_BYTES,
        ST_PAIR_CNT,
        ST_PAIR_VAL,
        ST_TERM0,
        ST_TERM1,
        ST_DONE
    } state_t;

    // Where the sequencer goes once a literal flush has drained
    typedef enum logic [1:0] {
        AF_PAIR,
        AF_POST,
        AF_TERM
    } after_t;

endpackage

[rtl/rle_literal_segment_encoder.sv]
// Channel | Handshake               | Beat
// --------+-------------------------+---------------------------------------------
// item    | item_valid / item_ready | item_t: data_byte, is_final
// word    | word_valid / word_ready | word_t: packed_bytes, byte_count, flags
//
// An input beat passes through idle, then close and post for each run it closes
// (close, then reopen or end), plus one emit state per encoded byte it causes (a
// sequencer drives a single byte-wide emit path into the word packer), and ends
// in done, which flushes any partly filled word.
// item_ready is high only in the idle state; a word beat is held in an output
// register, so the next item is taken while the last word still waits.
// A stalled word output stalls the sequencer when the packer must hand over a
// full word or flush the last one.
// Reset clears control state, run/literal counters and the packer; no clearing pass.
module rle_literal_segment_encoder
    import rle_lse_pkg::*;
#(
    parameter int MAX_LITERAL = rle_lse_pkg::LIT_MAX_DEF,
    parameter int MAX_RUN     = rle_lse_pkg::RUN_MAX_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  rle_lse_pkg::item_t  item,
    output logic                word_valid,
    input  logic                word_ready,
    output rle_lse_pkg::word_t  word
);

    localparam int IDX_W = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;
    localparam int LC_W  = $clog2(MAX_LITERAL + 1);
    localparam int RL_W  = $clog2(MAX_RUN + 1);

    state_t             state_reg, state_next;
    after_t             after_reg, after_next;
    logic               final_phase_reg, final_phase_next;
    logic [7:0]         byte_reg, byte_next;
    logic               fin_reg, fin_next;
    logic [7:0]         run_value_reg, run_value_next;
    logic [RL_W-1:0]    run_len_reg, run_len_next;
    logic [LC_W-1:0]    lit_cnt_reg, lit_cnt_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;

    logic [63:0]        pack_reg, pack_next;
    logic [3:0]         pack_cnt_reg, pack_cnt_next;
    logic               word_valid_reg, word_valid_next;
    word_t              word_reg, word_next;

    logic [7:0]         lit_mem [MAX_LITERAL];
    logic [7:0]         rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               mem_we;

    logic               emit_en;
    logic [7:0]         emit_byte;
    logic               out_free;
    logic               push_ok;
    logic               lit_last;
    logic               flush_word;

    assign item_ready = (state_reg == ST_IDLE);
    assign word_valid = word_valid_reg;
    assign word       = word_reg;

    assign out_free = !word_valid_reg || word_ready;
    assign push_ok  = (pack_cnt_reg != 4'(LANES)) || out_free;
    assign lit_last = (LC_W'(idx_reg) + LC_W'(1)) == lit_cnt_reg;

    // Literal store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lit_mem[lit_cnt_reg[IDX_W-1:0]] <= run_value_reg;
        end
        rd_data_reg <= lit_mem[rd_addr];
    end

    // Select the byte to emit in this state
    always_comb
    begin
        emit_en   = 1'b0;
        emit_byte = 8'h00;
        case (state_reg)
            ST_LIT_HDR0:
            begin
                emit_en = 1'b1;
            end
            ST_LIT_HDR1:
            begin
                emit_en   = 1'b1;
                emit_byte = 8'(lit_cnt_reg);
            end
            ST_LIT_BYTES:
            begin
                emit_en   = 1'b1;
                emit_byte = rd_data_reg;
            end
            ST_PAIR_CNT:
            begin
                emit_en   = 1'b1;
                emit_byte = 8'(run_len_reg);
            end
            ST_PAIR_VAL:
            begin
                emit_en   = 1'b1;
                emit_byte = run_value_reg;
            end
            ST_TERM0, ST_TERM1:
            begin
                emit_en = 1'b1;
            end
            default:
            begin
                emit_en   = 1'b0;
                emit_byte = 8'h00;
            end
        endcase
    end

    // Sequencer: next state and encoder state
    always_comb
    begin
        state_next       = state_reg;
        after_next       = after_reg;
        final_phase_next = final_phase_reg;
        byte_next        = byte_reg;
        fin_next         = fin_reg;
        run_value_next   = run_value_reg;
        run_len_next     = run_len_reg;
        lit_cnt_next     = lit_cnt_reg;
        idx_next         = idx_reg;
        mem_we           = 1'b0;
        rd_addr          = '0;
        flush_word       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    byte_next        = item.data_byte;
                    fin_next         = item.is_final;
                    final_phase_next = item.is_final;
                    if (run_len_reg == '0)
                    begin
                        run_value_next = item.data_byte;
                        run_len_next   = RL_W'(1);
                        state_next     = item.is_final ? ST_CLOSE : ST_DONE;
                    end
                    else if (item.data_byte == run_value_reg &&
                             run_len_reg < RL_W'(MAX_RUN))
                    begin
                        run_len_next = run_len_reg + RL_W'(1);
                        state_next   = item.is_final ? ST_CLOSE : ST_DONE;
                    end
                    else
                    begin
                        // close the old run first, the new byte follows
                        final_phase_next = 1'b0;
                        state_next       = ST_CLOSE;
                    end
                end
            end
            ST_CLOSE:
            begin
                if (run_len_reg == RL_W'(1))
                begin
                    // single byte joins the literal buffer, flush when full
                    mem_we       = 1'b1;
                    lit_cnt_next = lit_cnt_reg + LC_W'(1);
                    if (lit_cnt_reg == LC_W'(MAX_LITERAL - 1))
                    begin
                        after_next = AF_POST;
                        state_next = ST_LIT_HDR0;
                    end
                    else
                    begin
                        state_next = ST_POST;
                    end
                end
                else if (run_len_reg != '0)
                begin
                    if (lit_cnt_reg != '0)
                    begin
                        after_next = AF_PAIR;
                        state_next = ST_LIT_HDR0;
                    end
                    else
                    begin
                        state_next = ST_PAIR_CNT;
                    end
                end
                else
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                if (!final_phase_reg)
                begin
                    // open the new run with the held byte
                    run_value_next = byte_reg;
                    run_len_next   = RL_W'(1);
                    if (fin_reg)
                    begin
                        final_phase_next = 1'b1;
                        state_next       = ST_CLOSE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    // end of stream: drop the run, flush leftovers
                    run_value_next = 8'h00;
                    run_len_next   = '0;
                    if (lit_cnt_reg != '0)
                    begin
                        after_next = AF_TERM;
                        state_next = ST_LIT_HDR0;
                    end
                    else
                    begin
                        state_next = ST_TERM0;
                    end
                end
            end
            ST_LIT_HDR0:
            begin
                if (push_ok)
                begin
                    state_next = ST_LIT_HDR1;
                end
            end
            ST_LIT_HDR1:
            begin
                rd_addr = '0;
                if (push_ok)
                begin
                    idx_next   = '0;
                    state_next = ST_LIT_BYTES;
                end
            end
            ST_LIT_BYTES:
            begin
                rd_addr = idx_reg;
                if (push_ok)
                begin
                    if (lit_last)
                    begin
                        rd_addr      = '0;
                        lit_cnt_next = '0;
                        case (after_reg)
                            AF_PAIR: state_next = ST_PAIR_CNT;
                            AF_POST: state_next = ST_POST;
                            AF_TERM: state_next = ST_TERM0;
                            default: state_next = ST_POST;
                        endcase
                    end
                    else
                    begin
                        rd_addr  = idx_reg + IDX_W'(1);
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_PAIR_CNT:
            begin
                if (push_ok)
                begin
                    state_next = ST_PAIR_VAL;
                end
            end
            ST_PAIR_VAL:
            begin
                if (push_ok)
                begin
                    state_next = ST_POST;
                end
            end
            ST_TERM0:
            begin
                if (push_ok)
                begin
                    state_next = ST_TERM1;
                end
            end
            ST_TERM1:
            begin
                if (push_ok)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (pack_cnt_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    flush_word = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Word packer and output register
    always_comb
    begin
        pack_next       = pack_reg;
        pack_cnt_next   = pack_cnt_reg;
        word_next       = word_reg;
        word_valid_next = word_valid_reg && !word_ready;

        if (emit_en && push_ok)
        begin
            if (pack_cnt_reg == 4'(LANES))
            begin
                // hand over the full word, start a new one with this byte
                word_next.packed_bytes = pack_reg;
                word_next.byte_count   = pack_cnt_reg;
                word_next.last_of_item = 1'b0;
                word_next.stream_done  = 1'b0;
                word_valid_next        = 1'b1;
                pack_next              = {56'h0, emit_byte};
                pack_cnt_next          = 4'd1;
            end
            else
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    if (3'(i) == pack_cnt_reg[2:0])
                    begin
                        pack_next[8*i +: 8] = emit_byte;
                    end
                end
                pack_cnt_next = pack_cnt_reg + 4'd1;
            end
        end
        else if (flush_word)
        begin
            word_next.packed_bytes = pack_reg;
            word_next.byte_count   = pack_cnt_reg;
            word_next.last_of_item = 1'b1;
            word_next.stream_done  = fin_reg;
            word_valid_next        = 1'b1;
            pack_next              = '0;
            pack_cnt_next          = '0;
        end
    end

    // Control and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            after_reg       <= AF_POST;
            final_phase_reg <= 1'b0;
            fin_reg         <= 1'b0;
            run_value_reg   <= 8'h00;
            run_len_reg     <= '0;
            lit_cnt_reg     <= '0;
            pack_reg        <= '0;
            pack_cnt_reg    <= '0;
            word_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            after_reg       <= after_next;
            final_phase_reg <= final_phase_next;
            fin_reg         <= fin_next;
            run_value_reg   <= run_value_next;
            run_len_reg     <= run_len_next;
            lit_cnt_reg     <= lit_cnt_next;
            pack_reg        <= pack_next;
            pack_cnt_reg    <= pack_cnt_next;
            word_valid_reg  <= word_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        idx_reg  <= idx_next;
        word_reg <= word_next;
    end

endmodule

[rtl/rle_lse_checker.sv]
module rle_lse_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_ready,
    input  rle_lse_pkg::item_t  item,
    input  logic                word_valid,
    input  logic                word_ready,
    input  rle_lse_pkg::word_t  word
);

    // Hold a waiting item beat
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("item beat changed while waiting");

    // Hold a stalled word beat
    a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !word_ready |=> word_valid && $stable(word))
        else $error("word beat changed while stalled");

    // Byte count stays within one word
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid |-> (word.byte_count != 4'd0) && (word.byte_count <= 4'd8))
        else $error("byte_count out of range");

    // Only the last word of an item may be partly filled
    a_full_unless_last: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !word.last_of_item |-> word.byte_count == 4'd8)
        else $error("partial word before end of item");

    // Terminator word closes its item
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word.stream_done |-> word.last_of_item)
        else $error("stream_done on a word that does not end the item");

endmodule

bind rle_literal_segment_encoder rle_lse_checker u_rle_lse_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word       (word)
);

[dv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rle_lse_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES = 300;

    // Tracks the encoder state and holds the words it must emit, oldest first
    class encoded_word_board;
        logic [7:0]  lit_bytes [LIT_MAX_DEF];
        int unsigned lit_len;
        logic [7:0]  run_byte;
        int unsigned run_len;
        logic [7:0]  emit_bytes [$];
        word_t       expected_words [$];
        int unsigned mismatches;

        function new();
            lit_len    = 0;
            run_byte   = '0;
            run_len    = 0;
            mismatches = 0;
        endfunction

        // Emit the literal segment header and bytes, then empty the buffer
        function void spill_literals();
            if (lit_len == 0)
                return;
            emit_bytes.push_back(8'h00);
            emit_bytes.push_back(8'(lit_len));
            for (int k = 0; k < lit_len; k++)
                emit_bytes.push_back(lit_bytes[k]);
            lit_len = 0;
        endfunction

        // Gather a single byte; flush whenever the buffer is full
        function void push_literal(logic [7:0] b);
            if (lit_len >= LIT_MAX_DEF)
                spill_literals();
            lit_bytes[lit_len] = b;
            lit_len++;
            if (lit_len >= LIT_MAX_DEF)
                spill_literals();
        endfunction

        // Close the open run: a lone byte joins the literals, longer runs go out as a pair
        function void end_run();
            if (run_len == 1) begin
                push_literal(run_byte);
            end
            else if (run_len >= 2) begin
                spill_literals();
                emit_bytes.push_back(8'(run_len));
                emit_bytes.push_back(run_byte);
            end
            run_len = 0;
        endfunction

        // Advance the encoder by one accepted input beat and queue the words it causes
        function void absorb_byte(item_t it);
            int unsigned n_bytes;
            int unsigned n_words;
            int unsigned cnt;
            word_t       w;
            emit_bytes.delete();
            if (run_len == 0) begin
                run_byte = it.data_byte;
                run_len  = 1;
            end
            else if (it.data_byte == run_byte && run_len < RUN_MAX_DEF) begin
                run_len++;
            end
            else begin
                end_run();
                run_byte = it.data_byte;
                run_len  = 1;
            end
            // close out the stream and return to the reset state
            if (it.is_final) begin
                end_run();
                spill_literals();
                emit_bytes.push_back(8'h00);
                emit_bytes.push_back(8'h00);
                run_byte = '0;
                run_len  = 0;
                lit_len  = 0;
            end
            // pack eight bytes per word, earliest in the low lane
            n_bytes = emit_bytes.size();
            n_words = (n_bytes + 7) / 8;
            for (int k = 0; k < n_words; k++) begin
                cnt = n_bytes - k * 8;
                if (cnt > 8)
                    cnt = 8;
                w = '0;
                for (int j = 0; j < cnt; j++)
                    w.packed_bytes[8*j +: 8] = emit_bytes[k*8 + j];
                w.byte_count   = 4'(cnt);
                w.last_of_item = (k + 1 == n_words);
                w.stream_done  = it.is_final && (k + 1 == n_words);
                expected_words.push_back(w);
            end
        endfunction

        // Compare an accepted output beat with the oldest queued word
        function void match_word(word_t got);
            word_t want;
            if (expected_words.size() == 0) begin
                $error("unexpected word: packed_bytes %h byte_count %0d",
                       got.packed_bytes, got.byte_count);
                mismatches++;
                return;
            end
            want = expected_words.pop_front();
            if (got.packed_bytes !== want.packed_bytes) begin
                $error("packed_bytes: expected %h, actual %h",
                       want.packed_bytes, got.packed_bytes);
                mismatches++;
            end
            if (got.byte_count !== want.byte_count) begin
                $error("byte_count: expected %0d, actual %0d",
                       want.byte_count, got.byte_count);
                mismatches++;
            end
            if (got.last_of_item !== want.last_of_item) begin
                $error("last_of_item: expected %b, actual %b",
                       want.last_of_item, got.last_of_item);
                mismatches++;
            end
            if (got.stream_done !== want.stream_done) begin
                $error("stream_done: expected %b, actual %b",
                       want.stream_done, got.stream_done);
                mismatches++;
            end
        endfunction
    endclass

    logic  clk = 1'b0;
    logic  rst_n;
    logic  item_valid;
    logic  item_ready;
    item_t item;
    logic  word_valid;
    logic  word_ready;
    word_t word;

    encoded_word_board board = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned items_sent    = 0;
    bit          hold_req      = 1'b0;

    rle_literal_segment_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word       (word)
    );

    always #6 clk = ~clk;

    // Observe both channels at each edge; note the input beat before checking words
    always @(posedge clk)
    begin
        if (item_valid && item_ready)
            board.absorb_byte(item);
        if (word_valid && word_ready)
            board.match_word(word);
    end

    // Offer one byte, idling at random first, and hold it until accepted
    task automatic send_item(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= item_t'{data_byte: b, is_final: fin};
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Build a stream of runs and single bytes, or noise, and send it ending in a final beat
    task automatic send_random_stream();
        logic [7:0]  seq [$];
        logic [7:0]  b;
        int unsigned len;
        int unsigned seg;
        int unsigned mode;
        mode = $urandom_range(9);
        len  = $urandom_range(1, 24);
        while (seq.size() < len) begin
            if (mode < 7) begin
                b = 8'($urandom_range(255));
                if ($urandom_range(2) == 0)
                    seg = $urandom_range(2, ($urandom_range(7) == 0) ? 40 : 6);
                else
                    seg = 1;
                repeat (seg) seq.push_back(b);
            end
            else if (mode == 7) begin
                seq.push_back(8'($urandom_range(1)));
            end
            else begin
                seq.push_back(8'($urandom_range(255)));
            end
        end
        foreach (seq[i])
            send_item(seq[i], i == seq.size() - 1);
    endtask

    // Drive word_ready; on request hold it low for a long stretch
    initial
    begin : word_sink
        word_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                word_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else begin
                word_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // End the run when neither channel moves a beat for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((item_valid && item_ready) || (word_valid && word_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles often enough to space beats, receiver stalls most cycles
        send_idle_pct = 14;
        recv_idle_pct = 76;

        // one-byte streams at both extremes
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b1);
        // run still open at the final byte
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
        // literals, then a run that flushes them, then a lone final byte
        send_item(8'h01, 1'b0);
        send_item(8'h02, 1'b0);
        send_item(8'h03, 1'b0);
        send_item(8'h03, 1'b0);
        send_item(8'h03, 1'b0);
        send_item(8'h80, 1'b1);
        // literals only, flushed at the end
        send_item(8'h55, 1'b0);
        send_item(8'hAA, 1'b0);
        send_item(8'h55, 1'b1);
        // back-to-back runs of zero and all-ones
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);

        while (items_sent < 60)
            send_random_stream();

        // swap the idling of the two sides
        send_idle_pct = 76;
        recv_idle_pct = 14;
        while (items_sent < 115)
            send_random_stream();

        // no idling; stall the output long enough to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        while (items_sent < 165)
            send_random_stream();

        item_valid <= 1'b0;
        while (board.expected_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
